### sv/tfc_pkg.sv
// Package for the tolerant float compare unit: opcodes, double constants, stage types
// and the shared IEEE double add, floor and product rounding functions.
// Depends on nothing; every other file imports it.
package tfc_pkg;

   typedef enum logic [2:0] {
      OP_EQ    = 3'd0,
      OP_LT    = 3'd1,
      OP_LE    = 3'd2,
      OP_FLOOR = 3'd3,
      OP_CEIL  = 3'd4
   } op_type;

   localparam int unsigned RSP_LATENCY = 10;

   localparam logic [2:0]  ADDR_TOLERANCE = 3'h0;
   localparam logic [63:0] TOL_RESET      = 64'h3D30_0000_0000_0000;
   localparam logic [63:0] DBL_HALF       = 64'h3FE0_0000_0000_0000;
   localparam logic [63:0] DBL_ONE        = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DBL_NEG_ONE    = 64'hBFF0_0000_0000_0000;
   localparam logic [63:0] DBL_POS_ZERO   = 64'h0000_0000_0000_0000;
   localparam logic [63:0] DBL_NEG_ZERO   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] DBL_DEF_NAN    = 64'hFFF8_0000_0000_0000;

   typedef struct packed {
      logic        special;
      logic [63:0] sval;
      logic        sign;
      logic        zsign;
      logic [10:0] exp;
      logic [56:0] sum;
   } add_mid_type;

   typedef struct packed {
      logic nan_any;
      logic eq;
      logic lt;
      logic cand;
   } cls_type;

   function automatic logic [5:0] lzc56(input logic [55:0] x);
      logic [5:0] n;
      n = 6'd56;
      for (int i = 0; i < 56; i++) begin
         if (x[i]) n = 6'(55 - i);
      end
      return n;
   endfunction

   function automatic logic [6:0] lzc106(input logic [105:0] x);
      logic [6:0] n;
      n = 7'd106;
      for (int i = 0; i < 106; i++) begin
         if (x[i]) n = 7'(105 - i);
      end
      return n;
   endfunction

   // First half of a double addition: special operands, alignment and the raw sum.
   function automatic add_mid_type fp_add_align(input logic [63:0] a, input logic [63:0] b);
      add_mid_type r;
      logic        a_nan, b_nan, a_inf, b_inf, swap, eff_sub, stk;
      logic [63:0] big, sml;
      logic [10:0] eb, es, d;
      logic [52:0] mb, ms;
      logic [55:0] sext, shd, mask;
      a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
      b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
      swap  = a[62:0] < b[62:0];
      big   = swap ? b : a;
      sml   = swap ? a : b;
      eb    = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
      es    = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
      mb    = {big[62:52] != 11'd0, big[51:0]};
      ms    = {sml[62:52] != 11'd0, sml[51:0]};
      d     = eb - es;
      sext  = {ms, 3'b000};
      if (d >= 11'd56) begin
         shd  = '0;
         mask = '1;
         stk  = |ms;
      end else begin
         shd  = sext >> d[5:0];
         mask = ~({56{1'b1}} << d[5:0]);
         stk  = |(sext & mask);
      end
      shd[0]  = shd[0] | stk;
      eff_sub = a[63] ^ b[63];
      r.sum   = eff_sub ? ({1'b0, mb, 3'b000} - {1'b0, shd})
                        : ({1'b0, mb, 3'b000} + {1'b0, shd});
      r.sign  = big[63];
      r.zsign = eff_sub ? 1'b0 : a[63];
      r.exp   = eb;
      r.special = 1'b1;
      if (a_nan) begin
         r.sval = a | 64'h0008_0000_0000_0000;
      end else if (b_nan) begin
         r.sval = b | 64'h0008_0000_0000_0000;
      end else if (a_inf && b_inf) begin
         r.sval = (a[63] == b[63]) ? a : DBL_DEF_NAN;
      end else if (a_inf) begin
         r.sval = a;
      end else if (b_inf) begin
         r.sval = b;
      end else begin
         r.special = 1'b0;
         r.sval    = '0;
      end
      return r;
   endfunction

   // Second half: normalisation, round to nearest even and packing.
   function automatic logic [63:0] fp_add_round(input add_mid_type m);
      logic [5:0]  lz;
      logic [10:0] shl, lim;
      logic [55:0] s;
      logic [11:0] e;
      logic [53:0] mr;
      logic        up;
      logic [63:0] r;
      if (m.special) begin
         r = m.sval;
      end else if (m.sum == 57'd0) begin
         r = {m.zsign, 63'd0};
      end else begin
         if (m.sum[56]) begin
            s = {m.sum[56:2], m.sum[1] | m.sum[0]};
            e = {1'b0, m.exp} + 12'd1;
         end else begin
            lz  = lzc56(m.sum[55:0]);
            lim = m.exp - 11'd1;
            shl = ({5'd0, lz} < lim) ? {5'd0, lz} : lim;
            s   = m.sum[55:0] << shl;
            e   = {1'b0, m.exp - shl};
         end
         up = s[2] & (s[1] | s[0] | s[3]);
         mr = {1'b0, s[55:3]} + {53'd0, up};
         if (mr[53]) begin
            e  = e + 12'd1;
            mr = {2'b01, 52'd0};
         end
         if (e >= 12'd2047) begin
            r = {m.sign, 11'h7FF, 52'd0};
         end else begin
            r = {m.sign, mr[52] ? e[10:0] : 11'd0, mr[51:0]};
         end
      end
      return r;
   endfunction

   // Round towards minus infinity on the bit pattern.
   function automatic logic [63:0] fp_floor(input logic [63:0] d);
      logic [10:0] ex;
      logic [5:0]  e;
      logic [51:0] frac;
      logic [63:0] t, r;
      ex = d[62:52];
      if (ex >= 11'd1075) begin
         r = d;
      end else if (ex < 11'd1023) begin
         r = (d[62:0] == 63'd0) ? d : (d[63] ? DBL_NEG_ONE : DBL_POS_ZERO);
      end else begin
         e    = 6'(ex - 11'd1023);
         frac = ~({52{1'b1}} << (6'd52 - e));
         if ((d[51:0] & frac) == 52'd0) begin
            r = d;
         end else begin
            t = {d[63:52], d[51:0] & ~frac};
            r = d[63] ? (t + (64'd1 << (6'd52 - e))) : t;
         end
      end
      return r;
   endfunction

   // Rounds a positive 106-bit significand product to a double magnitude.
   function automatic logic [62:0] fp_mul_round(input logic [105:0] p, input logic [6:0] lz,
                                               input logic [11:0] esum);
      logic signed [13:0] rp_lead, rp_sub, rp, ef;
      logic [6:0]   rpc;
      logic [213:0] sh;
      logic [53:0]  q0, q;
      logic         g, st, up;
      logic [62:0]  r;
      rp_lead = 14'sd53 - $signed({7'd0, lz});
      rp_sub  = 14'sd1076 - $signed({2'd0, esum});
      rp      = (rp_lead > rp_sub) ? rp_lead : rp_sub;
      if (rp < 14'sd0) begin
         q = p[53:0] << 6'(-rp);
      end else begin
         rpc = (rp > 14'sd107) ? 7'd107 : 7'(rp);
         sh  = {p, 108'd0} >> rpc;
         q0  = sh[161:108];
         g   = sh[107];
         st  = |sh[106:0];
         up  = g & (st | q0[0]);
         q   = q0 + {53'd0, up};
      end
      ef = rp + $signed({2'd0, esum}) - 14'sd1075;
      if (q[53]) begin
         ef = ef + 14'sd1;
         q  = {2'b01, 52'd0};
      end
      if (!q[52]) begin
         r = {11'd0, q[51:0]};
      end else if (ef >= 14'sd2047) begin
         r = {11'h7FF, 52'd0};
      end else begin
         r = {ef[10:0], q[51:0]};
      end
      return r;
   endfunction

endpackage

### sv/tolerant_float_compare_unit.sv
// Top level of the tolerant float compare unit: a ten-stage pipeline and the tolerance register.
// Depends on tfc_pkg for the opcodes, constants and double arithmetic functions.
//
// Usage: a word (req_op, req_u_bits, req_v_bits) is taken at each rising edge where start is
// high and busy is low. busy stays low, so one word can be taken in every cycle.
// Each word gives exactly one result word on rsp_flag and rsp_value_bits, marked by rsp_valid
// for one cycle. Results leave in order. The pipeline holds the input register, two stages
// for the rounding add, one for the floor, one for alignment, three for the tolerance product
// and two for the final add.
// The tolerance register sits on an APB-style port at byte address 0 with 64-bit data. The user
// must write it only while no word is in flight; the block itself does not enforce this.
// Reset empties the pipeline and loads the default tolerance of two to the minus 44. The
// receiver cannot stall, so no result is ever held back.
module tolerant_float_compare_unit
   import tfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_u_bits,
   input  logic [63:0] req_v_bits,
   output logic        rsp_valid,
   output logic        rsp_flag,
   output logic [63:0] rsp_value_bits,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [63:0] tol_ff;
   logic [RSP_LATENCY-1:0] stg_vld_ff;

   logic [2:0]  op0_ff, op1_ff, op2_ff, op3_ff, op4_ff, op5_ff, op6_ff, op7_ff, op8_ff;
   logic [63:0] u0_ff, v0_ff, u1_ff, v1_ff, u2_ff, v2_ff;
   add_mid_type mid1_ff, dmid4_ff, mid8_ff;
   logic [63:0] s2_ff, a3_ff, b3_ff, x4_ff, x5_ff, x6_ff, x7_ff;
   cls_type     cls4_ff, cls5_ff, cls6_ff;
   logic [62:0] m4_ff, diff5_ff, diff6_ff;
   logic [53:0] pp_hh5_ff;
   logic [52:0] pp_hl5_ff, pp_lh5_ff;
   logic [51:0] pp_ll5_ff;
   logic [11:0] esum5_ff, esum6_ff;
   logic [105:0] p6_ff;
   logic [6:0]  lz6_ff;
   logic        flag7_ff, flag8_ff, flag_ff;
   logic [63:0] addend7_ff, value_ff;

   logic [63:0] x3_in, a3_in, diff5_full, prod_in, fin_in;
   cls_type     cls4_in;
   logic [62:0] m4_in, pmag7_in;
   logic [52:0] mt, mm;
   logic [10:0] et, em;
   logic [105:0] p6_in;
   logic        tol_nan, tol_inf, tol_zero, in_tol, teq, tlt, tle;
   logic        flag7_in;
   logic [63:0] addend7_in;
   logic        a_nan, b_nan, a_zero, b_zero, pos_a, pos_b, mag_lt;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_TOLERANCE) ? tol_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= TOL_RESET;
         stg_vld_ff <= '0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr == ADDR_TOLERANCE)) begin
            tol_ff <= pwdata;
         end
         stg_vld_ff <= {stg_vld_ff[RSP_LATENCY-2:0], start & ~busy};
      end
   end

   // Floor and operand selection, then operand classification for the tolerant compares.
   always_comb begin
      x3_in  = fp_floor(s2_ff);
      a3_in  = ((op2_ff == OP_FLOOR) || (op2_ff == OP_CEIL)) ? x3_in : u2_ff;
      a_nan  = (a3_ff[62:52] == 11'h7FF) && (a3_ff[51:0] != 52'd0);
      b_nan  = (b3_ff[62:52] == 11'h7FF) && (b3_ff[51:0] != 52'd0);
      a_zero = a3_ff[62:0] == 63'd0;
      b_zero = b3_ff[62:0] == 63'd0;
      pos_a  = !a3_ff[63] && !a_zero;
      pos_b  = !b3_ff[63] && !b_zero;
      mag_lt = a3_ff[62:0] < b3_ff[62:0];
      cls4_in.nan_any = a_nan || b_nan;
      cls4_in.eq = !cls4_in.nan_any && ((a3_ff == b3_ff) || (a_zero && b_zero));
      if (a3_ff[63] != b3_ff[63]) begin
         cls4_in.lt = a3_ff[63];
      end else begin
         cls4_in.lt = a3_ff[63] ? (b3_ff[62:0] < a3_ff[62:0]) : mag_lt;
      end
      cls4_in.lt   = cls4_in.lt && !cls4_in.nan_any && !cls4_in.eq;
      m4_in        = mag_lt ? b3_ff[62:0] : a3_ff[62:0];
      cls4_in.cand = !cls4_in.nan_any && !cls4_in.eq && (pos_a == pos_b) &&
                     (m4_in != {11'h7FF, 52'd0});
   end

   always_comb begin
      diff5_full = fp_add_round(dmid4_ff);
      mt = {tol_ff[62:52] != 11'd0, tol_ff[51:0]};
      mm = {m4_ff[62:52] != 11'd0, m4_ff[51:0]};
      et = (tol_ff[62:52] == 11'd0) ? 11'd1 : tol_ff[62:52];
      em = (m4_ff[62:52] == 11'd0) ? 11'd1 : m4_ff[62:52];
      p6_in = ({52'd0, pp_hh5_ff} << 52) + ({53'd0, pp_hl5_ff} << 26) +
              ({53'd0, pp_lh5_ff} << 26) + {54'd0, pp_ll5_ff};
   end

   always_comb begin
      pmag7_in = fp_mul_round(p6_ff, lz6_ff, esum6_ff);
      tol_nan  = (tol_ff[62:52] == 11'h7FF) && (tol_ff[51:0] != 52'd0);
      tol_inf  = (tol_ff[62:52] == 11'h7FF) && (tol_ff[51:0] == 52'd0);
      tol_zero = tol_ff[62:0] == 63'd0;
      in_tol   = !tol_nan && !tol_ff[63] &&
                 (tol_inf || (!tol_zero && (diff6_ff <= pmag7_in)));
      teq = cls6_ff.eq || (cls6_ff.cand && in_tol);
      tlt = cls6_ff.lt && !teq;
      tle = cls6_ff.lt || cls6_ff.eq || teq;
      flag7_in   = 1'b0;
      addend7_in = DBL_POS_ZERO;
      unique case (op6_ff)
         OP_EQ:    flag7_in = teq;
         OP_LT:    flag7_in = tlt;
         OP_LE:    flag7_in = tle;
         OP_FLOOR: addend7_in = tle ? DBL_NEG_ZERO : DBL_NEG_ONE;
         OP_CEIL:  addend7_in = tlt ? DBL_ONE : DBL_POS_ZERO;
         default:  flag7_in = 1'b0;
      endcase
      prod_in = fp_add_round(mid8_ff);
      fin_in  = ((op8_ff == OP_FLOOR) || (op8_ff == OP_CEIL)) ? prod_in : 64'd0;
   end

   always_ff @(posedge clock) begin
      op0_ff <= req_op;
      u0_ff  <= req_u_bits;
      v0_ff  <= req_v_bits;

      mid1_ff <= fp_add_align(DBL_HALF, v0_ff);
      op1_ff  <= op0_ff;
      u1_ff   <= u0_ff;
      v1_ff   <= v0_ff;

      s2_ff  <= fp_add_round(mid1_ff);
      op2_ff <= op1_ff;
      u2_ff  <= u1_ff;
      v2_ff  <= v1_ff;

      a3_ff  <= a3_in;
      b3_ff  <= v2_ff;
      op3_ff <= op2_ff;

      cls4_ff  <= cls4_in;
      m4_ff    <= m4_in;
      dmid4_ff <= fp_add_align({1'b0, a3_ff[62:0]}, {1'b1, b3_ff[62:0]});
      x4_ff    <= a3_ff;
      op4_ff   <= op3_ff;

      pp_hh5_ff <= 54'(mt[52:26]) * 54'(mm[52:26]);
      pp_hl5_ff <= 53'(mt[52:26]) * 53'(mm[25:0]);
      pp_lh5_ff <= 53'(mt[25:0]) * 53'(mm[52:26]);
      pp_ll5_ff <= 52'(mt[25:0]) * 52'(mm[25:0]);
      esum5_ff  <= {1'b0, et} + {1'b0, em};
      diff5_ff  <= diff5_full[62:0];
      cls5_ff   <= cls4_ff;
      x5_ff     <= x4_ff;
      op5_ff    <= op4_ff;

      p6_ff    <= p6_in;
      lz6_ff   <= lzc106(p6_in);
      esum6_ff <= esum5_ff;
      diff6_ff <= diff5_ff;
      cls6_ff  <= cls5_ff;
      x6_ff    <= x5_ff;
      op6_ff   <= op5_ff;

      flag7_ff   <= flag7_in;
      addend7_ff <= addend7_in;
      x7_ff      <= x6_ff;
      op7_ff     <= op6_ff;

      mid8_ff  <= fp_add_align(x7_ff, addend7_ff);
      flag8_ff <= flag7_ff;
      op8_ff   <= op7_ff;

      flag_ff  <= flag8_ff;
      value_ff <= fin_in;
   end

   assign rsp_valid      = stg_vld_ff[RSP_LATENCY-1];
   assign rsp_flag       = flag_ff;
   assign rsp_value_bits = value_ff;

endmodule

### sv/tfc_checker.sv
// Port-level checker for the tolerant float compare unit, bound to the top level.
// Depends on tfc_pkg for the opcodes and the result latency.
module tfc_checker
   import tfc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_op,
   input logic [63:0] req_u_bits,
   input logic [63:0] req_v_bits,
   input logic        rsp_valid,
   input logic        rsp_flag,
   input logic [63:0] rsp_value_bits
);

   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("accepted word gave no result at the expected cycle");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##RSP_LATENCY !rsp_valid)
      else $error("result appeared without an accepted word");

   a_flag_has_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flag) |-> (rsp_value_bits == 64'd0))
      else $error("compare result carries a value");

   a_identical_equal: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_EQ) && (req_u_bits == req_v_bits) &&
       !((req_u_bits[62:52] == 11'h7FF) && (req_u_bits[51:0] != 52'd0)))
      |-> ##RSP_LATENCY (rsp_valid && rsp_flag))
      else $error("identical operands not reported equal");

endmodule

bind tolerant_float_compare_unit tfc_checker u_tfc_checker (.*);

### test/tolerant_float_compare_unit_tb.sv
// Self-checking testbench for the tolerant float compare unit: directed and random words,
// several tolerance settings and random sender gaps, checked against an in-bench predictor.
// Depends on tfc_pkg and tolerant_float_compare_unit.
module tolerant_float_compare_unit_tb;
   import tfc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        flag;
      logic [63:0] value_bits;
   } outcome_type;

   class tfc_scoreboard;
      outcome_type pending[$];
      logic [63:0] tolerance = TOL_RESET;
      int unsigned mismatches = 0;

      function bit is_nan(logic [63:0] b);
         return b[62:52] == 11'h7FF && b[51:0] != 52'd0;
      endfunction

      function bit tol_equal(real u, real v);
         real m, diff;
         if (is_nan($realtobits(u)) || is_nan($realtobits(v))) return 0;
         if (u == v) return 1;
         if ((0.0 < u) != (0.0 < v)) return 0;
         m = (0.0 < u) ? ((u > v) ? u : v) : -((u < v) ? u : v);
         if ($realtobits(m) == 64'h7FF0_0000_0000_0000) return u == v;
         diff = u - v;
         if (diff < 0.0) diff = -diff;
         return diff <= $bitstoreal(tolerance) * m;
      endfunction

      function bit tol_less(real u, real v);
         return u < v && !tol_equal(u, v);
      endfunction

      function bit tol_less_equal(real u, real v);
         return u <= v || tol_equal(u, v);
      endfunction

      function real round_down(real d);
         logic [63:0] b, frac;
         logic [10:0] ex;
         real t;
         b = $realtobits(d);
         ex = b[62:52];
         if (ex >= 11'd1075) return d;
         if (ex < 11'd1023) begin
            if (b[62:0] == 63'd0) return d;
            return b[63] ? -1.0 : 0.0;
         end
         frac = (64'd1 << (52 - (ex - 11'd1023))) - 64'd1;
         if ((b & frac) == 64'd0) return d;
         t = $bitstoreal(b & ~frac);
         return b[63] ? t - 1.0 : t;
      endfunction

      function void note(logic [2:0] op, logic [63:0] u_bits, logic [63:0] v_bits);
         outcome_type o;
         real u, v, x;
         u = $bitstoreal(u_bits);
         v = $bitstoreal(v_bits);
         o.flag = 0;
         o.value_bits = '0;
         case (op)
            OP_EQ: o.flag = tol_equal(u, v);
            OP_LT: o.flag = tol_less(u, v);
            OP_LE: o.flag = tol_less_equal(u, v);
            OP_FLOOR: begin
               x = round_down(0.5 + v);
               if (!tol_less_equal(x, v)) x = x - 1.0;
               o.value_bits = $realtobits(x);
            end
            OP_CEIL: begin
               x = round_down(0.5 + v);
               if (tol_less(x, v)) x = x + 1.0;
               o.value_bits = $realtobits(x);
            end
            default: ;
         endcase
         pending.push_back(o);
      endfunction

      function void check(logic flag, logic [63:0] value_bits);
         outcome_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word: flag %0b value %h",
                                           flag, value_bits);
            return;
         end
         e = pending.pop_front();
         if (flag !== e.flag || value_bits !== e.value_bits) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected flag %0b value %h, got flag %0b value %h",
                        e.flag, e.value_bits, flag, value_bits);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [63:0] req_u_bits = '0;
   logic [63:0] req_v_bits = '0;
   logic        rsp_valid;
   logic        rsp_flag;
   logic [63:0] rsp_value_bits;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   tfc_scoreboard compare_board = new();
   int unsigned   gap_pct = 0;

   tolerant_float_compare_unit u_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) compare_board.check(rsp_flag, rsp_value_bits);
   end

   task automatic send_word(logic [2:0] op, logic [63:0] u_bits, logic [63:0] v_bits);
      while ($urandom_range(99) < gap_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_op <= op;
      req_u_bits <= u_bits;
      req_v_bits <= v_bits;
      do @(posedge clock); while (busy);
      compare_board.note(op, u_bits, v_bits);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (compare_board.pending.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [63:0] value);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= ADDR_TOLERANCE;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      compare_board.tolerance = value;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_double();
      logic [63:0] b;
      case ($urandom_range(7))
         0: b = {$urandom, $urandom};
         1: begin
            case ($urandom_range(7))
               0: b = DBL_POS_ZERO;
               1: b = DBL_NEG_ZERO;
               2: b = 64'h7FF0_0000_0000_0000;
               3: b = 64'hFFF0_0000_0000_0000;
               4: b = {1'($urandom_range(1)), 11'h7FF, 20'($urandom | 1), 32'($urandom)};
               5: b = {1'($urandom_range(1)), 11'd0, 20'($urandom), 32'($urandom)};
               6: b = {1'($urandom_range(1)), 63'h7FEF_FFFF_FFFF_FFFF};
               default: b = {1'($urandom_range(1)), 63'd1};
            endcase
         end
         2, 3: b = $realtobits(real'($urandom_range(4000)) / 4.0 - 500.0);
         default: b = {1'($urandom_range(1)), 11'($urandom_range(900, 1150)),
                       20'($urandom), 32'($urandom)};
      endcase
      return b;
   endfunction

   function automatic logic [63:0] near_double(logic [63:0] b);
      logic [63:0] n;
      n = b + 64'($urandom_range(600)) - 64'd300;
      if ($urandom_range(9) == 0) n[63] = ~n[63];
      return n;
   endfunction

   task automatic random_words(int unsigned count);
      logic [63:0] u, v;
      logic [2:0]  op;
      repeat (count) begin
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
         v = pick_double();
         if ($urandom_range(9) < 6) u = near_double(v);
         else u = pick_double();
         if (op >= OP_FLOOR && $urandom_range(2) == 0) v = near_double(
            $realtobits(real'($urandom_range(200)) / 2.0 - 50.0));
         send_word(op, u, v);
      end
   endtask

   logic [63:0] tol_set[8] = '{64'h0, 64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                               64'h7FF0_0000_0000_0000, 64'hBD30_0000_0000_0000,
                               64'h3EB0_0000_0000_0000, 64'h0000_0000_0000_0001,
                               TOL_RESET};

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_word(OP_EQ, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_word(OP_EQ, 64'h3FF0_0000_0000_0100, 64'h3FF0_0000_0000_0000);
      send_word(OP_EQ, 64'h3FF0_0000_0000_0101, 64'h3FF0_0000_0000_0000);
      send_word(OP_EQ, DBL_POS_ZERO, DBL_NEG_ZERO);
      send_word(OP_EQ, 64'h0000_0000_0000_0001, DBL_NEG_ZERO);
      send_word(OP_EQ, 64'h7FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF);
      send_word(OP_EQ, DBL_DEF_NAN, DBL_DEF_NAN);
      send_word(OP_LT, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0010);
      send_word(OP_LT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_word(OP_LT, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
      send_word(OP_LE, 64'h3FF0_0000_0000_0010, 64'h3FF0_0000_0000_0000);
      send_word(OP_LE, 64'h7FF8_0000_0000_0001, 64'h0);
      send_word(OP_FLOOR, 64'h0, 64'h4004_0000_0000_0000);
      send_word(OP_FLOOR, 64'h0, 64'h400B_FFFF_FFFF_FFF0);
      send_word(OP_FLOOR, 64'h0, 64'hC004_0000_0000_0000);
      send_word(OP_FLOOR, 64'h0, 64'hFFF0_0000_0000_0000);
      send_word(OP_FLOOR, 64'h0, 64'h7FF4_0000_0000_0000);
      send_word(OP_CEIL, 64'h0, 64'h4004_0000_0000_0000);
      send_word(OP_CEIL, 64'h0, 64'h4008_0000_0000_0010);
      send_word(OP_CEIL, 64'h0, DBL_NEG_ZERO);
      send_word(OP_CEIL, 64'h0, 64'h7FEF_FFFF_FFFF_FFFF);
      send_word(OP_CEIL, 64'h0, 64'h7FF0_0000_0000_0000);
      send_word(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(3'd7, 64'h1, 64'h1);
      for (int i = 0; i < 8; i++) begin
         drain();
         write_tolerance(tol_set[i]);
         gap_pct = (i < 3) ? 32 : (i < 6) ? 66 : 0;
         random_words(190);
      end
      drain();
      if (compare_board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
sv/tfc_pkg.sv
sv/tolerant_float_compare_unit.sv
sv/tfc_checker.sv
test/tolerant_float_compare_unit_tb.sv
